[hw/rtl/bitmap_font_glyph_rasterizer_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap font glyph rasteriser
// Shared shorthand for the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef BITMAP_FONT_GLYPH_RASTERIZER_DEFINES_SVH
`define BITMAP_FONT_GLYPH_RASTERIZER_DEFINES_SVH

// Check on every clock edge outside reset.
`define BFGR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check on every clock edge, reset included.
`define BFGR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/bfgr_pkg.sv]
// ---------------------------------------------------------------------------
// Bitmap font glyph rasteriser package
// Geometry constants, field widths and the types shared between modules.
// ---------------------------------------------------------------------------
`default_nettype none

package bfgr_pkg;

   // Glyph sheet geometry. SHEET_COLUMNS and SHEET_BYTES are powers of two.
   localparam int GLYPH_WIDTH      = 8;
   localparam int GLYPH_HEIGHT     = 8;
   localparam int SHEET_COLUMNS    = 32;
   localparam int ROW_BYTES        = 128;
   localparam int SHEET_BYTES      = 16384;
   localparam int FIRST_GLYPH_CODE = 33;
   localparam int NEWLINE_CODE     = 10;

   localparam int QUEUE_DEPTH = 4;

   localparam int ADDR_W  = $clog2(SHEET_BYTES);
   localparam int PX_W    = $clog2(GLYPH_WIDTH);
   localparam int PY_W    = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
   localparam int IDX_W   = 10;
   localparam int COLPX_W = $clog2(SHEET_COLUMNS * GLYPH_WIDTH);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam logic [7:0] COLOUR_RESET = 8'hFF;

   typedef enum logic [0:0] {
      OP_FONT_WRITE = 1'b0,
      OP_TEXT_CHAR  = 1'b1
   } bfgr_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FONT_READY   = 3'd0,
      CSR_STYLE_OFFSET = 3'd1,
      CSR_COLOUR_RED   = 3'd2,
      CSR_COLOUR_GREEN = 3'd3,
      CSR_COLOUR_BLUE  = 3'd4
   } bfgr_csr_type;

   typedef enum logic [0:0] {
      CMD_WRITE = 1'b0,
      CMD_DRAW  = 1'b1
   } bfgr_cmd_kind_type;

   typedef struct packed {
      bfgr_op_type        opcode;
      logic [13:0]        font_address;
      logic [7:0]         font_byte;
      logic [7:0]         char_code;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic               new_string;
      logic [13:0]        draw_priority;
   } bfgr_req_type;

   typedef struct packed {
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic [7:0]         pixel_red;
      logic [7:0]         pixel_green;
      logic [7:0]         pixel_blue;
      logic [13:0]        pixel_priority;
      logic               last_pixel;
   } bfgr_rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } bfgr_colour_type;

   // For a write, addr is the byte address; for a draw, it is the sheet
   // offset of the glyph's top row and col_px the glyph's first pixel column.
   typedef struct packed {
      bfgr_cmd_kind_type  kind;
      logic [ADDR_W-1:0]  addr;
      logic [7:0]         wbyte;
      logic [COLPX_W-1:0] col_px;
      logic [15:0]        origin_x;
      logic [15:0]        origin_y;
      logic [13:0]        prio;
   } bfgr_cmd_type;

endpackage

`default_nettype wire

[hw/rtl/bfgr_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bfgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/bfgr_front.sv]
// ---------------------------------------------------------------------------
// Glyph rasteriser front end
// Accepts requests, keeps the text cursor and queues font writes and draws.
// ---------------------------------------------------------------------------
`default_nettype none

module bfgr_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire bfgr_pkg::bfgr_req_type req_data,
   input  wire logic                   font_ready,
   input  wire logic [8:0]             style_offset,
   output logic                        q_push,
   output bfgr_pkg::bfgr_cmd_type      q_data,
   input  wire logic                   q_full
);

   localparam int IDX_W   = bfgr_pkg::IDX_W;
   localparam int ADDR_W  = bfgr_pkg::ADDR_W;
   localparam int COLPX_W = bfgr_pkg::COLPX_W;

   logic [15:0] cursor_x_ff, cursor_x_in;
   logic [15:0] cursor_y_ff, cursor_y_in;
   logic [15:0] line_start_x_ff, line_start_x_in;

   logic             accept;
   logic [15:0]      cur_x;
   logic [15:0]      cur_y;
   logic [15:0]      cur_ls;
   logic [IDX_W-1:0] glyph_idx;
   logic [IDX_W-1:0] glyph_row;
   logic [IDX_W-1:0] glyph_col;

   assign full   = q_full;
   assign accept = push && !q_full;

   always_comb begin
      cur_x  = cursor_x_ff;
      cur_y  = cursor_y_ff;
      cur_ls = line_start_x_ff;
      if (req_data.new_string) begin
         cur_x  = req_data.start_x;
         cur_y  = req_data.start_y;
         cur_ls = req_data.start_x;
      end

      // The code is at least the first glyph code whenever a draw is queued.
      glyph_idx = IDX_W'(req_data.char_code) + IDX_W'(style_offset)
                - IDX_W'(bfgr_pkg::FIRST_GLYPH_CODE);
      glyph_row = IDX_W'(glyph_idx / bfgr_pkg::SHEET_COLUMNS);
      glyph_col = IDX_W'(glyph_idx % bfgr_pkg::SHEET_COLUMNS);

      q_data.kind     = bfgr_pkg::CMD_DRAW;
      q_data.addr     = ADDR_W'(32'(glyph_row)
                      * 32'(bfgr_pkg::GLYPH_HEIGHT * bfgr_pkg::ROW_BYTES));
      q_data.wbyte    = req_data.font_byte;
      q_data.col_px   = COLPX_W'(32'(glyph_col) * 32'(bfgr_pkg::GLYPH_WIDTH));
      q_data.origin_x = cur_x;
      q_data.origin_y = cur_y;
      q_data.prio     = req_data.draw_priority;
      q_push          = 1'b0;

      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      line_start_x_in = line_start_x_ff;

      if (accept) begin
         unique case (req_data.opcode)
            bfgr_pkg::OP_FONT_WRITE: begin
               q_data.kind = bfgr_pkg::CMD_WRITE;
               q_data.addr = ADDR_W'(32'(req_data.font_address));
               q_push      = 1'b1;
            end
            bfgr_pkg::OP_TEXT_CHAR: begin
               if (font_ready) begin
                  line_start_x_in = cur_ls;
                  cursor_y_in     = cur_y;
                  if (req_data.char_code == 8'(bfgr_pkg::NEWLINE_CODE)) begin
                     cursor_x_in = cur_ls;
                     cursor_y_in = cur_y + 16'(bfgr_pkg::GLYPH_HEIGHT);
                  end else begin
                     q_push      = (32'(req_data.char_code)
                                    >= 32'(bfgr_pkg::FIRST_GLYPH_CODE));
                     cursor_x_in = cur_x + 16'(bfgr_pkg::GLYPH_WIDTH);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         line_start_x_ff <= '0;
      end else begin
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         line_start_x_ff <= line_start_x_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bfgr_queue.sv]
// ---------------------------------------------------------------------------
// Command queue
// Short first-in first-out store between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module bfgr_queue #(
   parameter int DEPTH = bfgr_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire bfgr_pkg::bfgr_cmd_type push_data,
   output logic                        full,
   input  wire logic                   pop,
   output bfgr_pkg::bfgr_cmd_type      pop_data,
   output logic                        empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bfgr_pkg::bfgr_cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bfgr_back.sv]
// ---------------------------------------------------------------------------
// Glyph rasteriser back end
// Owns the font sheet, performs writes and scans glyphs into pixels.
// ---------------------------------------------------------------------------
`default_nettype none

module bfgr_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_empty,
   output logic                           q_pop,
   input  wire bfgr_pkg::bfgr_cmd_type    q_data,
   input  wire bfgr_pkg::bfgr_colour_type colour,
   output logic                           empty,
   input  wire logic                      pop,
   output bfgr_pkg::bfgr_rsp_type         rsp_data
);

   localparam int ADDR_W  = bfgr_pkg::ADDR_W;
   localparam int PX_W    = bfgr_pkg::PX_W;
   localparam int PY_W    = bfgr_pkg::PY_W;
   localparam int COLPX_W = bfgr_pkg::COLPX_W;

   // Scan sequencer.
   logic                   scan_ff, scan_in;
   logic [PX_W-1:0]        px_ff, px_in;
   logic [PY_W-1:0]        py_ff, py_in;
   bfgr_pkg::bfgr_cmd_type ctx_ff, ctx_in;

   // Read data stage.
   logic            s2_valid_ff, s2_valid_in;
   logic            s2_last_ff, s2_last_in;
   logic [PX_W-1:0] s2_px_ff, s2_px_in;
   logic [PY_W-1:0] s2_py_ff, s2_py_in;
   logic [15:0]     s2_x_ff, s2_x_in;
   logic [15:0]     s2_y_ff, s2_y_in;
   logic [13:0]     s2_prio_ff, s2_prio_in;

   // Pixel held back until it is known whether it is the glyph's last.
   logic        hold_valid_ff, hold_valid_in;
   logic        hold_final_ff, hold_final_in;
   logic [15:0] hold_x_ff, hold_x_in;
   logic [15:0] hold_y_ff, hold_y_in;
   logic [13:0] hold_prio_ff, hold_prio_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic        out_last_ff, out_last_in;
   logic [15:0] out_x_ff, out_x_in;
   logic [15:0] out_y_ff, out_y_in;
   logic [13:0] out_prio_ff, out_prio_in;

   logic               go;
   logic               last_pos;
   logic               ram_we;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [7:0]         ram_rdata;
   logic [COLPX_W-1:0] colpx_sum;
   logic [3:0]         nibble;
   logic               hit;
   logic [15:0]        hit_x;
   logic [15:0]        hit_y;
   logic               s2_end;

   // The whole scan pipeline moves only when the output register can take
   // a pixel, so nothing is ever dropped on a stall.
   assign go       = !out_valid_ff || pop;
   assign q_pop    = !scan_ff && !q_empty;
   assign ram_we   = q_pop && (q_data.kind == bfgr_pkg::CMD_WRITE);
   assign ram_re   = go && scan_ff;
   assign last_pos = (px_ff == PX_W'(bfgr_pkg::GLYPH_WIDTH - 1))
                  && (py_ff == PY_W'(bfgr_pkg::GLYPH_HEIGHT - 1));

   assign colpx_sum = ctx_ff.col_px + COLPX_W'(px_ff);
   assign ram_raddr = ADDR_W'(32'(ctx_ff.addr)
                    + 32'(py_ff) * 32'(bfgr_pkg::ROW_BYTES)
                    + 32'(colpx_sum >> 1));

   bfgr_ram #(
      .WIDTH (8),
      .DEPTH (bfgr_pkg::SHEET_BYTES)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_data.addr),
      .wr_data (q_data.wbyte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      scan_in = scan_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      ctx_in  = ctx_ff;
      if (q_pop && (q_data.kind == bfgr_pkg::CMD_DRAW)) begin
         scan_in = 1'b1;
         px_in   = '0;
         py_in   = '0;
         ctx_in  = q_data;
      end else if (ram_re) begin
         if (px_ff == PX_W'(bfgr_pkg::GLYPH_WIDTH - 1)) begin
            px_in = '0;
            py_in = last_pos ? '0 : py_ff + 1'b1;
         end else begin
            px_in = px_ff + 1'b1;
         end
         scan_in = !last_pos;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_last_in  = s2_last_ff;
      s2_px_in    = s2_px_ff;
      s2_py_in    = s2_py_ff;
      s2_x_in     = s2_x_ff;
      s2_y_in     = s2_y_ff;
      s2_prio_in  = s2_prio_ff;
      if (go) begin
         s2_valid_in = scan_ff;
         s2_last_in  = last_pos;
         s2_px_in    = px_ff;
         s2_py_in    = py_ff;
         s2_x_in     = ctx_ff.origin_x;
         s2_y_in     = ctx_ff.origin_y;
         s2_prio_in  = ctx_ff.prio;
      end
   end

   // The odd pixel of each pair sits in the high nibble.
   assign nibble = s2_px_ff[0] ? ram_rdata[7:4] : ram_rdata[3:0];
   assign hit    = s2_valid_ff && (nibble == 4'h0);
   assign hit_x  = s2_x_ff + 16'(s2_px_ff);
   assign hit_y  = s2_y_ff + 16'(s2_py_ff);
   assign s2_end = s2_valid_ff && s2_last_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_final_in = hold_final_ff;
      hold_x_in     = hold_x_ff;
      hold_y_in     = hold_y_ff;
      hold_prio_in  = hold_prio_ff;
      out_valid_in  = out_valid_ff && !pop;
      out_last_in   = out_last_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_prio_in   = out_prio_ff;

      if (go) begin
         out_valid_in = 1'b0;
         if (hold_valid_ff && (hold_final_ff || hit)) begin
            out_valid_in = 1'b1;
            out_last_in  = hold_final_ff;
            out_x_in     = hold_x_ff;
            out_y_in     = hold_y_ff;
            out_prio_in  = hold_prio_ff;
         end

         if (hit) begin
            hold_valid_in = 1'b1;
            hold_final_in = s2_last_ff;
            hold_x_in     = hit_x;
            hold_y_in     = hit_y;
            hold_prio_in  = s2_prio_ff;
         end else if (hold_valid_ff && hold_final_ff) begin
            hold_valid_in = 1'b0;
         end else begin
            hold_final_in = hold_final_ff || s2_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff       <= 1'b0;
         s2_valid_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
         hold_final_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         scan_ff       <= scan_in;
         s2_valid_ff   <= s2_valid_in;
         hold_valid_ff <= hold_valid_in;
         hold_final_ff <= hold_final_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      ctx_ff       <= ctx_in;
      s2_last_ff   <= s2_last_in;
      s2_px_ff     <= s2_px_in;
      s2_py_ff     <= s2_py_in;
      s2_x_ff      <= s2_x_in;
      s2_y_ff      <= s2_y_in;
      s2_prio_ff   <= s2_prio_in;
      hold_x_ff    <= hold_x_in;
      hold_y_ff    <= hold_y_in;
      hold_prio_ff <= hold_prio_in;
      out_last_ff  <= out_last_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_prio_ff  <= out_prio_in;
   end

   assign empty                   = !out_valid_ff;
   assign rsp_data.pixel_x        = out_x_ff;
   assign rsp_data.pixel_y        = out_y_ff;
   assign rsp_data.pixel_red      = colour.red;
   assign rsp_data.pixel_green    = colour.green;
   assign rsp_data.pixel_blue     = colour.blue;
   assign rsp_data.pixel_priority = out_prio_ff;
   assign rsp_data.last_pixel     = out_last_ff;

endmodule

`default_nettype wire

[hw/rtl/bitmap_font_glyph_rasterizer.sv]
// ---------------------------------------------------------------------------
// Bitmap font glyph rasteriser
// Font sheet store and text-to-pixel generator with queue-style channels.
// ---------------------------------------------------------------------------
// Requests enter through push/full: a font write stores one sheet byte, a
// text character draws the glyph at the cursor and moves the cursor on.
// Each zero nibble of the glyph gives one pixel request on empty/pop, the
// final pixel of a character carrying last_pixel.
// The front end takes one request per cycle until its command queue is
// full. The back end starts a glyph and then scans its pixels in order,
// reading one sheet byte per pixel from the single read port of the font
// RAM, and takes no new command until that scan is finished.
// Each pixel is held until the next zero nibble or the end of the glyph
// shows whether it is the last.
// Newlines and codes without a glyph take no back end time at all.
// Reset clears the cursor, the queue and the pipeline and sets the colour
// registers to white; the font sheet keeps no reset value and must be
// written before use. When pop is held low the scan freezes once a pixel
// is waiting and keeps that pixel, and the front end keeps accepting until
// the queue fills. Registers are written through csr_write_en, csr_index
// and csr_wdata; the user must write them only while the block is idle,
// as the block itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_font_glyph_rasterizer #(
   parameter int QUEUE_DEPTH = bfgr_pkg::QUEUE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   output logic                                    full,
   input  wire bfgr_pkg::bfgr_req_type             req_data,
   output logic                                    empty,
   input  wire logic                               pop,
   output bfgr_pkg::bfgr_rsp_type                  rsp_data,
   input  wire logic                               csr_write_en,
   input  wire logic [bfgr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bfgr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                      font_ready_ff, font_ready_in;
   logic [8:0]                style_offset_ff, style_offset_in;
   bfgr_pkg::bfgr_colour_type colour_ff, colour_in;

   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_empty;
   bfgr_pkg::bfgr_cmd_type q_wr_data;
   bfgr_pkg::bfgr_cmd_type q_rd_data;

   always_comb begin
      font_ready_in   = font_ready_ff;
      style_offset_in = style_offset_ff;
      colour_in       = colour_ff;
      if (csr_write_en) begin
         unique case (bfgr_pkg::bfgr_csr_type'(csr_index))
            bfgr_pkg::CSR_FONT_READY:   font_ready_in   = csr_wdata[0];
            bfgr_pkg::CSR_STYLE_OFFSET: style_offset_in = csr_wdata[8:0];
            bfgr_pkg::CSR_COLOUR_RED:   colour_in.red   = csr_wdata[7:0];
            bfgr_pkg::CSR_COLOUR_GREEN: colour_in.green = csr_wdata[7:0];
            bfgr_pkg::CSR_COLOUR_BLUE:  colour_in.blue  = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_ready_ff   <= 1'b0;
         style_offset_ff <= '0;
         colour_ff.red   <= bfgr_pkg::COLOUR_RESET;
         colour_ff.green <= bfgr_pkg::COLOUR_RESET;
         colour_ff.blue  <= bfgr_pkg::COLOUR_RESET;
      end else begin
         font_ready_ff   <= font_ready_in;
         style_offset_ff <= style_offset_in;
         colour_ff       <= colour_in;
      end
   end

   bfgr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .font_ready   (font_ready_ff),
      .style_offset (style_offset_ff),
      .q_push       (q_push),
      .q_data       (q_wr_data),
      .q_full       (q_full)
   );

   bfgr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   bfgr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_data   (q_rd_data),
      .colour   (colour_ff),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

[hw/rtl/bfgr_checker.sv]
// ---------------------------------------------------------------------------
// Glyph rasteriser port checker
// Watches the top-level ports for pixel request ordering and framing.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bitmap_font_glyph_rasterizer_defines.svh"

module bfgr_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   empty,
   input wire logic                   pop,
   input wire bfgr_pkg::bfgr_rsp_type rsp_data
);

   // Tracks a character whose pixels have started but not yet finished.
   logic        open_ff, open_in;
   logic [15:0] open_y_ff, open_y_in;
   logic [13:0] open_prio_ff, open_prio_in;
   logic        taken;
   logic [15:0] y_step;

   assign taken  = pop && !empty;
   assign y_step = rsp_data.pixel_y - open_y_ff;

   always_comb begin
      open_in      = open_ff;
      open_y_in    = open_y_ff;
      open_prio_in = open_prio_ff;
      if (taken) begin
         open_in      = !rsp_data.last_pixel;
         open_y_in    = rsp_data.pixel_y;
         open_prio_in = rsp_data.pixel_priority;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      open_y_ff    <= open_y_in;
      open_prio_ff <= open_prio_in;
   end

   `BFGR_ASSERT(a_rsp_held, clock, reset, (!empty && !pop) |=> !empty, "pixel request withdrawn")
   `BFGR_ASSERT(a_rsp_stable, clock, reset, (!empty && !pop) |=> $stable(rsp_data), "pixel changed while stalled")
   `BFGR_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> empty, "pixel present after reset")
   `BFGR_ASSERT(a_glyph_priority, clock, reset, (taken && open_ff) |-> (rsp_data.pixel_priority == open_prio_ff), "priority changed within a character")
   `BFGR_ASSERT(a_glyph_rows, clock, reset, (taken && open_ff) |-> (y_step < 16'(bfgr_pkg::GLYPH_HEIGHT)), "pixel row outside the glyph")

endmodule

bind bitmap_font_glyph_rasterizer bfgr_checker u_bfgr_checker (.*);

`default_nettype wire

[verif/tb_bitmap_font_glyph_rasterizer.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bitmap font glyph rasteriser testbench
// Loads glyphs into the font sheet, sends text characters under several
// register settings and compares every pixel with a local prediction.
// ---------------------------------------------------------------------------

module tb_bitmap_font_glyph_rasterizer;

   localparam int RANDOM_ITEMS = 370;
   localparam int DRAIN_CYCLES = 500;

   typedef enum int {
      FILL_ZERO,
      FILL_BLANK,
      FILL_RANDOM,
      FILL_SPARSE
   } glyph_fill_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 push = 1'b0;
   logic                                 full;
   bfgr_pkg::bfgr_req_type               req_data = '0;
   logic                                 empty;
   logic                                 pop = 1'b0;
   bfgr_pkg::bfgr_rsp_type               rsp_data;
   logic                                 csr_write_en = 1'b0;
   logic [bfgr_pkg::CSR_INDEX_W-1:0]     csr_index = bfgr_pkg::CSR_FONT_READY;
   logic [bfgr_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   // Predicted state of the block.
   logic [7:0]                sheet_mem [bfgr_pkg::SHEET_BYTES];
   bit                        sheet_written [bfgr_pkg::SHEET_BYTES];
   logic [15:0]               pen_x = '0;
   logic [15:0]               pen_y = '0;
   logic [15:0]               margin_x = '0;
   logic                      ready_cfg = 1'b0;
   logic [8:0]                style_cfg = '0;
   bfgr_pkg::bfgr_colour_type colour_cfg = {bfgr_pkg::COLOUR_RESET, bfgr_pkg::COLOUR_RESET,
                                            bfgr_pkg::COLOUR_RESET};

   bfgr_pkg::bfgr_rsp_type expected_pixels [$];
   int                     error_count = 0;
   int                     burst_left = 0;
   int                     pop_mode = 0;
   int                     pop_cycles = 0;
   int                     hold_left = 0;

   bitmap_font_glyph_rasterizer dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .empty        (empty),
      .pop          (pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // The receiver changes its habits every so often: no stalls at all,
   // coin-toss stalls, or long alternating runs of stall and pop.
   always @(negedge clock) begin
      if (pop_cycles == 0) begin
         pop_mode <= $urandom_range(0, 2);
         pop_cycles <= $urandom_range(20, 200);
      end else begin
         pop_cycles <= pop_cycles - 1;
      end
      case (pop_mode)
         0: begin
            pop <= 1'b1;
         end
         1: begin
            pop <= ($urandom_range(0, 1) == 1);
         end
         default: begin
            if (hold_left == 0) begin
               pop <= ~pop;
               hold_left <= $urandom_range(1, 12);
            end else begin
               hold_left <= hold_left - 1;
            end
         end
      endcase
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic int sheet_addr(input int idx, input int py, input int px);
      int row;
      int col;
      row = idx / bfgr_pkg::SHEET_COLUMNS;
      col = idx % bfgr_pkg::SHEET_COLUMNS;
      return ((row * bfgr_pkg::GLYPH_HEIGHT + py) * bfgr_pkg::ROW_BYTES
             + (col * bfgr_pkg::GLYPH_WIDTH + px) / 2) % bfgr_pkg::SHEET_BYTES;
   endfunction

   function automatic logic [3:0] glyph_nibble(input int idx, input int py, input int px);
      logic [7:0] sheet_byte;
      sheet_byte = sheet_mem[sheet_addr(idx, py, px)];
      return (px % 2 == 1) ? sheet_byte[7:4] : sheet_byte[3:0];
   endfunction

   function automatic int glyph_index(input logic [7:0] code);
      return int'(code) - bfgr_pkg::FIRST_GLYPH_CODE + int'(style_cfg);
   endfunction

   // Works out the pixels a request draws and moves the predicted cursor on.
   task automatic predict_pixels(input bfgr_pkg::bfgr_req_type item);
      int                     idx;
      int                     hits;
      int                     seen;
      bfgr_pkg::bfgr_rsp_type pixel;
      if (item.opcode == bfgr_pkg::OP_FONT_WRITE) begin
         sheet_mem[item.font_address] = item.font_byte;
         sheet_written[item.font_address] = 1'b1;
         return;
      end
      if (!ready_cfg)
         return;
      if (item.new_string) begin
         pen_x = item.start_x;
         pen_y = item.start_y;
         margin_x = item.start_x;
      end
      if (item.char_code == bfgr_pkg::NEWLINE_CODE) begin
         pen_x = margin_x;
         pen_y = 16'(pen_y + bfgr_pkg::GLYPH_HEIGHT);
         return;
      end
      if (item.char_code >= bfgr_pkg::FIRST_GLYPH_CODE) begin
         idx = glyph_index(item.char_code);
         hits = 0;
         for (int py = 0; py < bfgr_pkg::GLYPH_HEIGHT; py++)
            for (int px = 0; px < bfgr_pkg::GLYPH_WIDTH; px++)
               if (glyph_nibble(idx, py, px) == 4'h0)
                  hits++;
         seen = 0;
         for (int py = 0; py < bfgr_pkg::GLYPH_HEIGHT; py++) begin
            for (int px = 0; px < bfgr_pkg::GLYPH_WIDTH; px++) begin
               if (glyph_nibble(idx, py, px) == 4'h0) begin
                  seen++;
                  pixel.pixel_x = 16'(pen_x + px);
                  pixel.pixel_y = 16'(pen_y + py);
                  pixel.pixel_red = colour_cfg.red;
                  pixel.pixel_green = colour_cfg.green;
                  pixel.pixel_blue = colour_cfg.blue;
                  pixel.pixel_priority = item.draw_priority;
                  pixel.last_pixel = (seen == hits);
                  expected_pixels.push_back(pixel);
               end
            end
         end
      end
      pen_x = 16'(pen_x + bfgr_pkg::GLYPH_WIDTH);
   endtask

   task automatic check_pixel(input bfgr_pkg::bfgr_rsp_type got);
      bfgr_pkg::bfgr_rsp_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected pixel at x=%0d y=%0d",
                                   got.pixel_x, got.pixel_y));
         return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x)
         report_mismatch($sformatf("pixel_x %0d, expected %0d", got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
         report_mismatch($sformatf("pixel_y %0d, expected %0d", got.pixel_y, want.pixel_y));
      if (got.pixel_red !== want.pixel_red)
         report_mismatch($sformatf("pixel_red %0d, expected %0d",
                                   got.pixel_red, want.pixel_red));
      if (got.pixel_green !== want.pixel_green)
         report_mismatch($sformatf("pixel_green %0d, expected %0d",
                                   got.pixel_green, want.pixel_green));
      if (got.pixel_blue !== want.pixel_blue)
         report_mismatch($sformatf("pixel_blue %0d, expected %0d",
                                   got.pixel_blue, want.pixel_blue));
      if (got.pixel_priority !== want.pixel_priority)
         report_mismatch($sformatf("pixel_priority %0d, expected %0d",
                                   got.pixel_priority, want.pixel_priority));
      if (got.last_pixel !== want.last_pixel)
         report_mismatch($sformatf("last_pixel %0b, expected %0b",
                                   got.last_pixel, want.last_pixel));
   endtask

   always @(posedge clock) begin
      if (!reset && pop && !empty)
         check_pixel(rsp_data);
   end

   // Sends one request; the sender works in bursts with random gaps between.
   task automatic send_request(input bfgr_pkg::bfgr_req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            push <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (full)
         @(posedge clock);
      predict_pixels(item);
   endtask

   // Waits until every pixel has come out and the back end has had time to
   // finish any glyph that draws nothing.
   task automatic drain_pipeline();
      @(negedge clock);
      push <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input bfgr_pkg::bfgr_csr_type index,
                                 input logic [8:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (index)
         bfgr_pkg::CSR_FONT_READY:   ready_cfg = value[0];
         bfgr_pkg::CSR_STYLE_OFFSET: style_cfg = value;
         bfgr_pkg::CSR_COLOUR_RED:   colour_cfg.red = value[7:0];
         bfgr_pkg::CSR_COLOUR_GREEN: colour_cfg.green = value[7:0];
         bfgr_pkg::CSR_COLOUR_BLUE:  colour_cfg.blue = value[7:0];
         default: ;
      endcase
   endtask

   function automatic bfgr_pkg::bfgr_req_type random_request();
      bfgr_pkg::bfgr_req_type r;
      logic [31:0]            a;
      logic [31:0]            b;
      a = $urandom;
      b = $urandom;
      r.opcode = a[0] ? bfgr_pkg::OP_TEXT_CHAR : bfgr_pkg::OP_FONT_WRITE;
      r.font_address = a[14:1];
      r.font_byte = a[22:15];
      r.char_code = a[30:23];
      r.new_string = a[31];
      r.start_x = b[15:0];
      r.start_y = b[31:16];
      r.draw_priority = 14'($urandom_range(0, 16383));
      return r;
   endfunction

   function automatic bfgr_pkg::bfgr_req_type text_request(input logic [7:0] code,
                                                           input logic fresh);
      bfgr_pkg::bfgr_req_type r;
      r = random_request();
      r.opcode = bfgr_pkg::OP_TEXT_CHAR;
      r.char_code = code;
      r.new_string = fresh;
      return r;
   endfunction

   function automatic logic [3:0] sparse_nibble();
      return ($urandom_range(0, 1) == 1) ? 4'h0 : 4'($urandom_range(1, 15));
   endfunction

   // Writes every sheet byte that the glyph at idx covers.
   task automatic load_glyph(input int idx, input glyph_fill_type fill);
      bfgr_pkg::bfgr_req_type item;
      for (int py = 0; py < bfgr_pkg::GLYPH_HEIGHT; py++) begin
         for (int px = 0; px < bfgr_pkg::GLYPH_WIDTH; px += 2) begin
            item = random_request();
            item.opcode = bfgr_pkg::OP_FONT_WRITE;
            item.font_address = 14'(sheet_addr(idx, py, px));
            case (fill)
               FILL_ZERO:   item.font_byte = 8'h00;
               FILL_BLANK:  item.font_byte = 8'hFF;
               FILL_SPARSE: item.font_byte = {sparse_nibble(), sparse_nibble()};
               default:     item.font_byte = 8'($urandom_range(0, 255));
            endcase
            send_request(item);
         end
      end
   endtask

   // A glyph may only be drawn once all of its sheet bytes hold known data.
   function automatic bit glyph_loaded(input logic [7:0] code);
      int idx;
      idx = glyph_index(code);
      for (int py = 0; py < bfgr_pkg::GLYPH_HEIGHT; py++)
         for (int px = 0; px < bfgr_pkg::GLYPH_WIDTH; px += 2)
            if (!sheet_written[sheet_addr(idx, py, px)])
               return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_code();
      logic [7:0] drawable [$];
      int         roll;
      roll = $urandom_range(0, 15);
      if (roll == 0)
         return 8'(bfgr_pkg::NEWLINE_CODE);
      if (roll == 1)
         return 8'($urandom_range(0, bfgr_pkg::FIRST_GLYPH_CODE - 1));
      for (int c = bfgr_pkg::FIRST_GLYPH_CODE; c <= 255; c++)
         if (glyph_loaded(8'(c)))
            drawable.push_back(8'(c));
      if (drawable.size() == 0)
         return 8'($urandom_range(0, bfgr_pkg::FIRST_GLYPH_CODE - 1));
      return drawable[$urandom_range(0, drawable.size() - 1)];
   endfunction

   function automatic logic [7:0] pick_colour();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // With the font not ready, characters must neither draw nor move the
   // cursor, and new_string must be ignored.
   task automatic test_font_not_ready();
      bfgr_pkg::bfgr_req_type item;
      item = text_request(8'(bfgr_pkg::FIRST_GLYPH_CODE), 1'b1);
      item.start_x = 16'sh7FFF;
      send_request(item);
      send_request(text_request(8'(bfgr_pkg::NEWLINE_CODE), 1'b1));
      send_request(text_request(8'd0, 1'b0));
      send_request(text_request(8'd255, 1'b1));
   endtask

   // Glyph 0 holds sheet address zero, glyph 511 the top address.
   task automatic test_sheet_load();
      load_glyph(0, FILL_ZERO);
      load_glyph(bfgr_pkg::SHEET_BYTES
                 / (bfgr_pkg::GLYPH_HEIGHT * bfgr_pkg::GLYPH_WIDTH / 2) - 1, FILL_BLANK);
   endtask

   task automatic test_first_glyphs();
      bfgr_pkg::bfgr_req_type item;
      drain_pipeline();
      write_register(bfgr_pkg::CSR_FONT_READY, 9'd1);
      item = text_request(8'(bfgr_pkg::FIRST_GLYPH_CODE), 1'b0);
      item.draw_priority = 14'h3FFF;
      send_request(item);
      // Positions near the top of the range wrap while the glyph is drawn.
      item = text_request(8'(bfgr_pkg::FIRST_GLYPH_CODE), 1'b1);
      item.start_x = 16'sh7FFF;
      item.start_y = 16'sh7FFD;
      item.draw_priority = 14'h0000;
      send_request(item);
      send_request(text_request(8'd0, 1'b0));
      send_request(text_request(8'd32, 1'b0));
      send_request(text_request(8'(bfgr_pkg::NEWLINE_CODE), 1'b0));
      send_request(text_request(8'(bfgr_pkg::FIRST_GLYPH_CODE), 1'b0));
      item = text_request(8'(bfgr_pkg::FIRST_GLYPH_CODE), 1'b1);
      item.start_x = 16'sh8000;
      item.start_y = 16'sh8000;
      send_request(item);
   endtask

   task automatic test_style_and_wrap();
      bfgr_pkg::bfgr_req_type item;
      drain_pipeline();
      write_register(bfgr_pkg::CSR_STYLE_OFFSET, 9'd511);
      write_register(bfgr_pkg::CSR_COLOUR_RED, 9'd0);
      write_register(bfgr_pkg::CSR_COLOUR_GREEN, 9'd0);
      write_register(bfgr_pkg::CSR_COLOUR_BLUE, 9'd0);
      // Glyph index 512 lies past the end of the sheet and reads glyph 0.
      item = text_request(8'(bfgr_pkg::FIRST_GLYPH_CODE + 1), 1'b1);
      item.start_x = 16'sd100;
      item.start_y = -16'sd5;
      send_request(item);
      drain_pipeline();
      write_register(bfgr_pkg::CSR_STYLE_OFFSET, 9'd289);
      write_register(bfgr_pkg::CSR_COLOUR_RED, 9'd255);
      write_register(bfgr_pkg::CSR_COLOUR_GREEN, 9'd0);
      write_register(bfgr_pkg::CSR_COLOUR_BLUE, 9'd128);
      // Code 255 now selects the blank glyph: no pixels, but the cursor moves.
      send_request(text_request(8'd255, 1'b0));
      drain_pipeline();
      write_register(bfgr_pkg::CSR_STYLE_OFFSET, 9'd0);
      send_request(text_request(8'(bfgr_pkg::FIRST_GLYPH_CODE), 1'b0));
   endtask

   task automatic test_random_text();
      bfgr_pkg::bfgr_req_type item;
      glyph_fill_type         fill;
      logic [7:0]             code;
      int                     counted;
      int                     roll;
      int                     len;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            drain_pipeline();
            write_register(bfgr_pkg::CSR_FONT_READY,
                           ($urandom_range(0, 5) == 0) ? 9'd0 : 9'd1);
            case ($urandom_range(0, 3))
               0:       write_register(bfgr_pkg::CSR_STYLE_OFFSET, 9'd0);
               1:       write_register(bfgr_pkg::CSR_STYLE_OFFSET, 9'd511);
               default: write_register(bfgr_pkg::CSR_STYLE_OFFSET,
                                       9'($urandom_range(0, 511)));
            endcase
            write_register(bfgr_pkg::CSR_COLOUR_RED, {1'b0, pick_colour()});
            write_register(bfgr_pkg::CSR_COLOUR_GREEN, {1'b0, pick_colour()});
            write_register(bfgr_pkg::CSR_COLOUR_BLUE, {1'b0, pick_colour()});
         end else if (roll < 30) begin
            case ($urandom_range(0, 9))
               0:       fill = FILL_ZERO;
               1:       fill = FILL_BLANK;
               2, 3:    fill = FILL_RANDOM;
               default: fill = FILL_SPARSE;
            endcase
            load_glyph(glyph_index(8'($urandom_range(bfgr_pkg::FIRST_GLYPH_CODE, 255))),
                       fill);
            counted += bfgr_pkg::GLYPH_HEIGHT * bfgr_pkg::GLYPH_WIDTH / 2;
         end else if (roll < 38) begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               item = random_request();
               item.opcode = bfgr_pkg::OP_FONT_WRITE;
               send_request(item);
            end
            counted += len;
         end else begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
               code = ready_cfg ? pick_code() : 8'($urandom_range(0, 255));
               item = text_request(code, (k == 0) || ($urandom_range(0, 7) == 0));
               send_request(item);
            end
            counted += len;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_font_not_ready();
      test_sheet_load();
      test_first_glyphs();
      test_style_and_wrap();
      test_random_text();
      drain_pipeline();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/bfgr_pkg.sv
hw/rtl/bfgr_ram.sv
hw/rtl/bfgr_front.sv
hw/rtl/bfgr_queue.sv
hw/rtl/bfgr_back.sv
hw/rtl/bitmap_font_glyph_rasterizer.sv
hw/rtl/bfgr_checker.sv
verif/tb_bitmap_font_glyph_rasterizer.sv
